@@ rtl/nlms_echo_canceller_unit_assert.svh @@
// Assertion macros for the echo canceller.
`ifndef NLMS_ECHO_CANCELLER_UNIT_ASSERT_SVH
`define NLMS_ECHO_CANCELLER_UNIT_ASSERT_SVH
// same-cycle implication, sampled on clk, off during reset
`define NLMS_ASSERT_SAME(lbl, ant, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
        else $error("nlms assertion failed");
// next-cycle implication
`define NLMS_ASSERT_NEXT(lbl, ant, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
        else $error("nlms assertion failed");
`endif

@@ rtl/nlms_pkg.sv @@
// Package: constants, types and helpers of the echo canceller.
`default_nettype none
package nlms_pkg;
    localparam int TAPS      = 64;
    localparam int IDX_W     = 6;
    localparam int SAMPLE_W  = 16;
    localparam int TAP_W     = 32;
    localparam int STEP_W    = 16;
    localparam logic [STEP_W-1:0] STEP_RESET = 16'd16384;
    localparam int PROD_W    = SAMPLE_W + TAP_W;
    localparam int ACC_W     = PROD_W + $clog2(TAPS) + 1;
    localparam int EN_W      = 2 * SAMPLE_W + $clog2(TAPS);
    localparam int DEN_W     = EN_W + 1;
    localparam int MAG_W     = STEP_W + SAMPLE_W;
    localparam int GAIN_SH   = 31;
    localparam int NUM_W     = MAG_W + GAIN_SH;
    localparam int GAIN_W    = 48;
    localparam int FRAC      = 30;
    localparam int UPD_SH    = 15;
    localparam int CNT_MAX   = (TAPS + 2 > NUM_W) ? TAPS + 2 : NUM_W;
    localparam int CNT_W     = $clog2(CNT_MAX + 1);
    localparam int DCNT_W    = $clog2(NUM_W);

    typedef enum logic [2:0] {
        ST_IDLE, ST_SCAN, ST_DRAIN, ST_FORM, ST_MUL, ST_DIV, ST_UPD, ST_OUT
    } state_t;

    typedef struct packed {
        logic shift;
        logic rotate;
        logic update;
    } cell_ctrl_t;

    // Q45 sum to Q15: round half up, saturate to 16 bits
    function automatic logic [SAMPLE_W-1:0] round_sat(input logic signed [ACC_W:0] v);
        logic signed [ACC_W:0] r;
        r = (v + ((ACC_W+1)'(1) <<< (FRAC - 1))) >>> FRAC;
        if (&r[ACC_W:SAMPLE_W-1] || ~|r[ACC_W:SAMPLE_W-1])
            return r[SAMPLE_W-1:0];
        else
            return r[ACC_W] ? {1'b1, {(SAMPLE_W-1){1'b0}}} : {1'b0, {(SAMPLE_W-1){1'b1}}};
    endfunction
endpackage
`default_nettype wire

@@ rtl/nlms_if.sv @@
// Channel interfaces: sample/load input, result output, step size write.
`default_nettype none
interface nlms_in_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 action;
    logic [nlms_pkg::IDX_W-1:0]           tap_index;
    logic signed [nlms_pkg::TAP_W-1:0]    tap_value;
    logic signed [nlms_pkg::SAMPLE_W-1:0] sample;
    modport source (output valid, action, tap_index, tap_value, sample, input ready);
    modport sink (input valid, action, tap_index, tap_value, sample, output ready);
endinterface

interface nlms_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [nlms_pkg::SAMPLE_W-1:0] echo_sample;
    logic signed [nlms_pkg::SAMPLE_W-1:0] estimate_sample;
    logic signed [nlms_pkg::SAMPLE_W-1:0] error_sample;
    modport source (output valid, echo_sample, estimate_sample, error_sample, input ready);
    modport sink (input valid, echo_sample, estimate_sample, error_sample, output ready);
endinterface

interface nlms_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [nlms_pkg::STEP_W-1:0]   data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

@@ rtl/nlms_cell.sv @@
// One tap cell: delay sample, adaptive tap and echo path tap.
`default_nettype none
module nlms_cell (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire nlms_pkg::cell_ctrl_t                 ctrl,
    input  wire logic                                 load_en,
    input  wire logic signed [nlms_pkg::TAP_W-1:0]    load_val,
    input  wire logic signed [nlms_pkg::SAMPLE_W-1:0] x_left,
    input  wire logic signed [nlms_pkg::SAMPLE_W-1:0] x_ring,
    input  wire logic signed [nlms_pkg::TAP_W-1:0]    w_ring,
    input  wire logic signed [nlms_pkg::TAP_W-1:0]    h_ring,
    output logic signed [nlms_pkg::SAMPLE_W-1:0]      x,
    output logic signed [nlms_pkg::TAP_W-1:0]         w,
    output logic signed [nlms_pkg::TAP_W-1:0]         h
);
    logic signed [nlms_pkg::SAMPLE_W-1:0] x_reg;
    logic signed [nlms_pkg::TAP_W-1:0]    w_reg;
    logic signed [nlms_pkg::TAP_W-1:0]    h_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg <= '0;
            w_reg <= '0;
        end
        else if (ctrl.shift)
        begin
            x_reg <= x_left;
        end
        else if (ctrl.rotate || ctrl.update)
        begin
            x_reg <= x_ring;
            w_reg <= w_ring;
        end
    end

    // echo path: no reset, valid once loaded
    always_ff @(posedge clk)
    begin
        if (load_en)
            h_reg <= load_val;
        else if (ctrl.rotate)
            h_reg <= h_ring;
    end

    assign x = x_reg;
    assign w = w_reg;
    assign h = h_reg;
endmodule
`default_nettype wire

@@ rtl/nlms_div.sv @@
// Restoring divider, one quotient bit per cycle, for the update gain.
`default_nettype none
module nlms_div (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    input  wire logic [nlms_pkg::MAG_W-1:0]     mag,
    input  wire logic [nlms_pkg::DEN_W-1:0]     den,
    output logic                                done,
    output logic [nlms_pkg::NUM_W-1:0]          quot
);
    logic                            busy_reg;
    logic                            done_reg;
    logic [nlms_pkg::DCNT_W-1:0]     cnt_reg;
    logic [nlms_pkg::DEN_W-1:0]      den_reg;
    logic [nlms_pkg::DEN_W-1:0]      rem_reg;
    logic [nlms_pkg::NUM_W-1:0]      num_reg;
    logic [nlms_pkg::NUM_W-1:0]      quot_reg;
    logic [nlms_pkg::DEN_W:0]        trial;
    logic                            ge;
    logic [nlms_pkg::DEN_W:0]        diff;
    logic [nlms_pkg::DEN_W-1:0]      rem_next;

    always_comb
    begin
        trial    = {rem_reg, num_reg[nlms_pkg::NUM_W-1]};
        ge       = trial >= {1'b0, den_reg};
        diff     = trial - {1'b0, den_reg};
        rem_next = ge ? diff[nlms_pkg::DEN_W-1:0] : trial[nlms_pkg::DEN_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == nlms_pkg::DCNT_W'(nlms_pkg::NUM_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            den_reg  <= den;
            rem_reg  <= '0;
            num_reg  <= {mag, {nlms_pkg::GAIN_SH{1'b0}}};
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg  <= rem_next;
            num_reg  <= {num_reg[nlms_pkg::NUM_W-2:0], 1'b0};
            quot_reg <= {quot_reg[nlms_pkg::NUM_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;
endmodule
`default_nettype wire

@@ rtl/nlms_echo_canceller_unit.sv @@
// Top level: NLMS echo canceller built as a rotating ring of tap cells.
//
//  channel   | dir | payload                                      | handshake
//  in_ch     | in  | action, tap_index, tap_value, sample         | valid/ready
//  out_ch    | out | echo_sample, estimate_sample, error_sample   | valid/ready
//  cfg_ch    | in  | data (step size, Q2.14)                      | valid/ready
//
// A load item writes one echo path tap and leaves the unit idle. A sample item takes
// one ring rotation for the three inner products, 63 divider steps for the
// gain, and one rotation through the update stage for the taps.
// Reset clears delay line and adaptive taps, sets step size to 1.0; echo path is unset.
// A result waiting on out_ch stalls only the next sample's final hand-off.
`default_nettype none
module nlms_echo_canceller_unit (
    input  wire logic      clk,
    input  wire logic      rst_n,
    nlms_in_if.sink        in_ch,
    nlms_out_if.source     out_ch,
    nlms_cfg_if.sink       cfg_ch
);
    localparam int T  = nlms_pkg::TAPS;
    localparam int SW = nlms_pkg::SAMPLE_W;
    localparam int TW = nlms_pkg::TAP_W;

    nlms_pkg::state_t                 state_reg, state_next;
    logic [nlms_pkg::CNT_W-1:0]       cnt_reg, cnt_next;
    logic [nlms_pkg::STEP_W-1:0]      step_reg;
    nlms_pkg::cell_ctrl_t             ctrl;

    logic signed [SW-1:0] x_arr [T];
    logic signed [TW-1:0] w_arr [T];
    logic signed [TW-1:0] h_arr [T];

    logic in_acc;
    logic out_acc;

    logic signed [nlms_pkg::PROD_W-1:0]   pd_reg, py_reg;
    logic [2*SW-1:0]                      pe_reg;
    logic                                 pv_reg;
    logic signed [nlms_pkg::ACC_W-1:0]    dacc_reg, yacc_reg;
    logic [nlms_pkg::EN_W-1:0]            en_reg;
    logic signed [SW-1:0]                 d_reg, y_reg, e_reg;

    logic [SW-1:0]                        e_abs;
    logic [nlms_pkg::MAG_W-1:0]           mag;
    logic [nlms_pkg::DEN_W-1:0]           den;
    logic                                 div_done;
    logic [nlms_pkg::NUM_W-1:0]           quot;
    logic [nlms_pkg::GAIN_W-2:0]          q_sat;
    logic signed [nlms_pkg::GAIN_W-1:0]   gain_reg;

    logic signed [SW-1:0]                 xs_reg;
    logic signed [TW-1:0]                 ws_reg;
    logic signed [SW+16-1:0]              phi_reg;
    logic signed [SW+33-1:0]              plo_reg;
    logic signed [63:0]                   upd_v, upd_t, upd_sum;
    logic signed [TW-1:0]                 w_new;

    logic signed [SW-1:0] out_e_reg, out_y_reg, out_d_reg;
    logic                 out_valid_reg;

    assign in_ch.ready  = (state_reg == nlms_pkg::ST_IDLE);
    assign cfg_ch.ready = 1'b1;
    assign in_acc       = in_ch.valid && in_ch.ready;
    assign out_acc      = out_valid_reg && out_ch.ready;

    assign ctrl.shift  = in_acc && in_ch.action;
    assign ctrl.rotate = (state_reg == nlms_pkg::ST_SCAN);
    assign ctrl.update = (state_reg == nlms_pkg::ST_UPD);

    // ring of cells
    for (genvar i = 0; i < T; i++)
    begin : g_cell
        logic signed [SW-1:0] xl, xr;
        logic signed [TW-1:0] wr, hr;
        if (i == 0)
        begin : g_head
            assign xl = in_ch.sample;
        end
        else
        begin : g_body
            assign xl = x_arr[i-1];
        end
        if (i == T - 1)
        begin : g_tail
            assign xr = ctrl.update ? xs_reg : x_arr[0];
            assign wr = ctrl.update ? w_new : w_arr[0];
            assign hr = h_arr[0];
        end
        else
        begin : g_link
            assign xr = x_arr[i+1];
            assign wr = w_arr[i+1];
            assign hr = h_arr[i+1];
        end
        nlms_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (ctrl),
            .load_en  (in_acc && !in_ch.action && (32'(in_ch.tap_index) == i)),
            .load_val (in_ch.tap_value),
            .x_left   (xl),
            .x_ring   (xr),
            .w_ring   (wr),
            .h_ring   (hr),
            .x        (x_arr[i]),
            .w        (w_arr[i]),
            .h        (h_arr[i])
        );
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= nlms_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            nlms_pkg::ST_IDLE:
            begin
                cnt_next = '0;
                if (in_acc && in_ch.action)
                    state_next = nlms_pkg::ST_SCAN;
            end
            nlms_pkg::ST_SCAN:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == nlms_pkg::CNT_W'(T - 1))
                    state_next = nlms_pkg::ST_DRAIN;
            end
            nlms_pkg::ST_DRAIN: state_next = nlms_pkg::ST_FORM;
            nlms_pkg::ST_FORM:  state_next = nlms_pkg::ST_MUL;
            nlms_pkg::ST_MUL:   state_next = nlms_pkg::ST_DIV;
            nlms_pkg::ST_DIV:
            begin
                cnt_next = '0;
                if (div_done)
                    state_next = nlms_pkg::ST_UPD;
            end
            nlms_pkg::ST_UPD:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == nlms_pkg::CNT_W'(T))
                    state_next = nlms_pkg::ST_OUT;
            end
            nlms_pkg::ST_OUT:
            begin
                if (!out_valid_reg || out_ch.ready)
                    state_next = nlms_pkg::ST_IDLE;
            end
            default: state_next = nlms_pkg::ST_IDLE;
        endcase
    end

    // step size
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_reg <= nlms_pkg::STEP_RESET;
        else if (cfg_ch.valid && cfg_ch.ready)
            step_reg <= cfg_ch.data;
    end

    // inner products at the head of the ring
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pv_reg <= 1'b0;
        else
            pv_reg <= ctrl.rotate;
    end

    always_ff @(posedge clk)
    begin
        pd_reg <= x_arr[0] * h_arr[0];
        py_reg <= x_arr[0] * w_arr[0];
        pe_reg <= (2*SW)'(x_arr[0] * x_arr[0]);
        if (ctrl.shift)
        begin
            dacc_reg <= '0;
            yacc_reg <= '0;
            en_reg   <= '0;
        end
        else if (pv_reg)
        begin
            dacc_reg <= dacc_reg + nlms_pkg::ACC_W'(pd_reg);
            yacc_reg <= yacc_reg + nlms_pkg::ACC_W'(py_reg);
            en_reg   <= en_reg + nlms_pkg::EN_W'(pe_reg);
        end
        if (state_reg == nlms_pkg::ST_FORM)
        begin
            d_reg <= nlms_pkg::round_sat((nlms_pkg::ACC_W+1)'(dacc_reg));
            y_reg <= nlms_pkg::round_sat((nlms_pkg::ACC_W+1)'(yacc_reg));
            e_reg <= nlms_pkg::round_sat((nlms_pkg::ACC_W+1)'(dacc_reg)
                                         - (nlms_pkg::ACC_W+1)'(yacc_reg));
        end
    end

    // gain = step * |e| * 2^31 / (energy + 1)
    assign e_abs = e_reg[SW-1] ? (~e_reg + 1'b1) : e_reg;
    assign mag   = step_reg * e_abs;
    assign den   = nlms_pkg::DEN_W'(en_reg) + 1'b1;

    nlms_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (state_reg == nlms_pkg::ST_MUL),
        .mag   (mag),
        .den   (den),
        .done  (div_done),
        .quot  (quot)
    );

    assign q_sat = (|quot[nlms_pkg::NUM_W-1:nlms_pkg::GAIN_W-1]) ? '1
                                                               : quot[nlms_pkg::GAIN_W-2:0];

    always_ff @(posedge clk)
    begin
        if (div_done)
            gain_reg <= e_reg[SW-1] ? -$signed({1'b0, q_sat}) : $signed({1'b0, q_sat});
    end

    // update stage: one extra ring slot between head and tail
    always_ff @(posedge clk)
    begin
        xs_reg  <= x_arr[0];
        ws_reg  <= w_arr[0];
        phi_reg <= x_arr[0] * $signed(gain_reg[nlms_pkg::GAIN_W-1:32]);
        plo_reg <= x_arr[0] * $signed({1'b0, gain_reg[31:0]});
    end

    always_comb
    begin
        upd_v   = {32'(phi_reg), 32'b0} + 64'(plo_reg);
        upd_t   = (upd_v + (64'sd1 <<< (nlms_pkg::UPD_SH - 1))) >>> nlms_pkg::UPD_SH;
        upd_sum = 64'(ws_reg) + upd_t;
        if (&upd_sum[63:TW-1] || ~|upd_sum[63:TW-1])
            w_new = upd_sum[TW-1:0];
        else
            w_new = upd_sum[63] ? {1'b1, {(TW-1){1'b0}}} : {1'b0, {(TW-1){1'b1}}};
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (state_reg == nlms_pkg::ST_OUT && (!out_valid_reg || out_ch.ready))
            out_valid_reg <= 1'b1;
        else if (out_acc)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == nlms_pkg::ST_OUT && (!out_valid_reg || out_ch.ready))
        begin
            out_d_reg <= d_reg;
            out_y_reg <= y_reg;
            out_e_reg <= e_reg;
        end
    end

    assign out_ch.valid           = out_valid_reg;
    assign out_ch.echo_sample     = out_d_reg;
    assign out_ch.estimate_sample = out_y_reg;
    assign out_ch.error_sample    = out_e_reg;

`include "nlms_echo_canceller_unit_assert.svh"
    `NLMS_ASSERT_NEXT(a_sample_starts, in_acc && in_ch.action, state_reg == nlms_pkg::ST_SCAN)
    `NLMS_ASSERT_NEXT(a_load_idle, in_acc && !in_ch.action, state_reg == nlms_pkg::ST_IDLE)
    `NLMS_ASSERT_SAME(a_scan_cnt, state_reg == nlms_pkg::ST_SCAN, cnt_reg < nlms_pkg::CNT_W'(T))
    `NLMS_ASSERT_SAME(a_div_state, div_done, state_reg == nlms_pkg::ST_DIV)
    `NLMS_ASSERT_NEXT(a_out_hold, state_reg == nlms_pkg::ST_OUT && out_valid_reg && !out_ch.ready, state_reg == nlms_pkg::ST_OUT)
endmodule
`default_nettype wire
